FILE: sv/tlvd_pkg.sv
// Shared types and constants for the TLV stream deframer.
package tlvd_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    KIND_BOX     = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_VALUE   = 3'd2,
    KIND_END_OK  = 3'd3,
    KIND_END_ERR = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_BOX   = 3'd1,
    PH_ELEM  = 3'd2,
    PH_ITEM  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_LEN   = 3'd5,
    PH_VALUE = 3'd6
  } phase_e;

  typedef enum logic [0:0] {
    REG_BOX_ID_PRESENT  = 1'd0,
    REG_ITEM_ID_PRESENT = 1'd1
  } reg_idx_e;

  // One classified input byte: an optional main result and an optional end result.
  typedef struct packed {
    logic        has_res;
    kind_e       kind;
    logic [31:0] ident;
    logic [15:0] elem_type;
    logic [15:0] elem_length;
    logic [7:0]  value_byte;
    logic        value_last;
    logic        has_end;
    logic        end_ok;
    logic [15:0] count;
  } tlvd_entry_t;

endpackage

FILE: sv/tlvd_front.sv
// Front end: accepts message bytes, tracks the field parser and classifies each byte.
module tlvd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  box_en_i,
  input  logic                  item_en_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  in_stall_o,
  input  logic                  full_i,
  output logic                  push_o,
  output tlvd_pkg::tlvd_entry_t entry_o
);
  import tlvd_pkg::*;

  phase_e      phase_q, phase_d, ph;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d, sh32;
  logic [15:0] sh16;
  logic [31:0] item_q, item_d;
  logic [15:0] type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] rem_q, rem_d, rem_m1;
  logic [15:0] done_q, done_d, done_inc;
  logic        accept;
  logic        complete;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept & (entry_o.has_res | entry_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pos_q   <= '0;
      shift_q <= '0;
      item_q  <= '0;
      type_q  <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      done_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      item_q  <= item_d;
      type_q  <= type_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    item_d   = item_q;
    type_d   = type_q;
    len_d    = len_q;
    rem_d    = rem_q;
    done_d   = done_q;
    entry_o  = '0;
    complete = 1'b0;
    sh32     = {shift_q[23:0], data_byte_i};
    sh16     = {shift_q[7:0], data_byte_i};
    rem_m1   = rem_q - 16'd1;
    done_inc = (done_q == 16'hFFFF) ? done_q : done_q + 16'd1;

    // Boundary phases resolve within the same byte.
    ph = phase_q;
    if (ph == PH_START) begin
      ph = box_en_i ? PH_BOX : PH_ELEM;
    end
    if (ph == PH_ELEM) begin
      if (item_en_i) begin
        ph = PH_ITEM;
      end else begin
        ph     = PH_TYPE;
        item_d = '0;
      end
    end
    phase_d = ph;

    unique case (ph)
      PH_BOX, PH_ITEM: begin
        if (pos_q == 2'd3) begin
          if (ph == PH_BOX) begin
            entry_o.has_res = 1'b1;
            entry_o.kind    = KIND_BOX;
            entry_o.ident   = sh32;
            phase_d         = PH_ELEM;
          end else begin
            item_d  = sh32;
            phase_d = PH_TYPE;
          end
          pos_d   = '0;
          shift_d = '0;
        end else begin
          pos_d   = pos_q + 2'd1;
          shift_d = sh32;
        end
      end
      PH_TYPE, PH_LEN: begin
        if (pos_q == 2'd1) begin
          pos_d   = '0;
          shift_d = '0;
          if (ph == PH_TYPE) begin
            type_d  = sh16;
            phase_d = PH_LEN;
          end else begin
            len_d               = sh16;
            entry_o.has_res     = 1'b1;
            entry_o.kind        = KIND_HEADER;
            entry_o.ident       = item_q;
            entry_o.elem_type   = type_q;
            entry_o.elem_length = sh16;
            if (sh16 == 16'd0) begin
              complete = 1'b1;
            end else begin
              rem_d   = sh16;
              phase_d = PH_VALUE;
            end
          end
        end else begin
          pos_d   = pos_q + 2'd1;
          shift_d = {16'd0, sh16};
        end
      end
      PH_VALUE: begin
        rem_d               = rem_m1;
        entry_o.has_res     = 1'b1;
        entry_o.kind        = KIND_VALUE;
        entry_o.ident       = item_q;
        entry_o.elem_type   = type_q;
        entry_o.elem_length = len_q;
        entry_o.value_byte  = data_byte_i;
        entry_o.value_last  = (rem_m1 == 16'd0);
        complete            = (rem_m1 == 16'd0);
      end
      default: begin
        phase_d = PH_ELEM;
        pos_d   = '0;
        shift_d = '0;
      end
    endcase

    if (complete) begin
      done_d  = done_inc;
      phase_d = PH_ELEM;
      pos_d   = '0;
      shift_d = '0;
    end

    if (last_byte_i) begin
      entry_o.has_end = 1'b1;
      entry_o.end_ok  = (phase_d == PH_ELEM);
      entry_o.count   = done_d;
      phase_d = PH_START;
      pos_d   = '0;
      shift_d = '0;
      item_d  = '0;
      type_d  = '0;
      len_d   = '0;
      rem_d   = '0;
      done_d  = '0;
    end
  end

  a_value_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (rem_q != 16'd0))
    else $error("value phase with no bytes remaining");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_TYPE) || (phase_q == PH_LEN)) |-> (pos_q[1] == 1'b0))
    else $error("field position past a 16-bit field");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push while queue is full");

endmodule

FILE: sv/tlvd_fifo.sv
// Short queue of classified items between the front and back ends.
module tlvd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tlvd_pkg::tlvd_entry_t wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output tlvd_pkg::tlvd_entry_t rdata_o
);
  import tlvd_pkg::*;

  tlvd_entry_t         mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue count overflow");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + FifoCntW'(1)))
    else $error("queue count did not follow push");

endmodule

FILE: sv/tlvd_back.sv
// Back end: expands each queued item into its results and holds the output register.
module tlvd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  tlvd_pkg::tlvd_entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [31:0]           box_ident_o,
  output logic [31:0]           item_ident_o,
  output logic [15:0]           elem_type_o,
  output logic [15:0]           elem_length_o,
  output logic [7:0]            value_byte_o,
  output logic                  value_last_o,
  output logic [15:0]           element_count_o,
  output logic                  run_last_o
);
  import tlvd_pkg::*;

  logic        stage_q, stage_d;
  logic        ov_q, ov_d;
  kind_e       kind_q, kind_d;
  logic [31:0] box_q, box_d, item_q, item_d;
  logic [15:0] type_q, type_d, len_q, len_d, cnt_q, cnt_d;
  logic [7:0]  vb_q, vb_d;
  logic        vl_q, vl_d, rl_q, rl_d;
  logic        out_free;

  assign out_free = ~ov_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      stage_q <= stage_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    box_q  <= box_d;
    item_q <= item_d;
    type_q <= type_d;
    len_q  <= len_d;
    vb_q   <= vb_d;
    vl_q   <= vl_d;
    cnt_q  <= cnt_d;
    rl_q   <= rl_d;
  end

  always_comb begin
    stage_d = stage_q;
    ov_d    = ov_q;
    kind_d  = kind_q;
    box_d   = box_q;
    item_d  = item_q;
    type_d  = type_q;
    len_d   = len_q;
    vb_d    = vb_q;
    vl_d    = vl_q;
    cnt_d   = cnt_q;
    rl_d    = rl_q;
    pop_o   = 1'b0;
    if (out_free) begin
      if (valid_i) begin
        ov_d   = 1'b1;
        box_d  = '0;
        item_d = '0;
        type_d = '0;
        len_d  = '0;
        vb_d   = '0;
        vl_d   = 1'b0;
        cnt_d  = '0;
        if (!stage_q && entry_i.has_res) begin
          kind_d = entry_i.kind;
          if (entry_i.kind == KIND_BOX) begin
            box_d = entry_i.ident;
          end else begin
            item_d = entry_i.ident;
          end
          type_d = entry_i.elem_type;
          len_d  = entry_i.elem_length;
          vb_d   = entry_i.value_byte;
          vl_d   = entry_i.value_last;
          rl_d   = ~entry_i.has_end;
          if (entry_i.has_end) begin
            stage_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d  = entry_i.end_ok ? KIND_END_OK : KIND_END_ERR;
          cnt_d   = entry_i.count;
          rl_d    = 1'b1;
          pop_o   = 1'b1;
          stage_d = 1'b0;
        end
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign box_ident_o     = box_q;
  assign item_ident_o    = item_q;
  assign elem_type_o     = type_q;
  assign elem_length_o   = len_q;
  assign value_byte_o    = vb_q;
  assign value_last_o    = vl_q;
  assign element_count_o = cnt_q;
  assign run_last_o      = rl_q;

  a_stage_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q |-> valid_i)
    else $error("second result pending without a queued item");

  a_end_after_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stage_q) |-> (ov_q && !rl_q))
    else $error("main result of a two-result item marked as run end");

  a_pop_on_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (ov_q && rl_q) || (ov_q && !$past(stage_q) && !$past(entry_i.has_end)))
    else $error("item popped without its closing result");

endmodule

FILE: sv/tlv_stream_deframer_core.sv
// Top level of the TLV stream deframer: configuration registers, front, queue and back.
// A byte's results are written into the queue, then taken into the back end's output register.
// Throughput: one byte per cycle unless the queue is full; a byte that closes a message and
// yields a header, value or box id gives two results in turn from the single output register.
// Reset clears both configuration bits, returns the parser to message start and
// empties the four-entry queue; no clearing pass is needed.
module tlv_stream_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] box_ident_o,
  output logic [31:0] item_ident_o,
  output logic [15:0] elem_type_o,
  output logic [15:0] elem_length_o,
  output logic [7:0]  value_byte_o,
  output logic        value_last_o,
  output logic [15:0] element_count_o,
  output logic        run_last_o
);
  import tlvd_pkg::*;

  // Configuration bits. The front end samples the box id bit at the first byte
  // of a message and the item id bit at the first byte of each element.
  logic box_en_q, item_en_q;

  // Front to queue and queue to back.
  logic        push, full, pop, q_valid;
  tlvd_entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_en_q  <= 1'b0;
      item_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BOX_ID_PRESENT:  box_en_q  <= cfg_data_i[0];
        REG_ITEM_ID_PRESENT: item_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front end parses each accepted byte in its own cycle and leaves at most
  // one queue entry, carrying the byte's main result and its end-of-message result.
  tlvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_en_i    (box_en_q),
    .item_en_i   (item_en_q),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // The queue absorbs output stalls so that the parser keeps taking bytes until it fills.
  tlvd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  // The back end turns each entry into one or two results, zeroing the fields
  // that do not apply to a result's kind, and marks the last one with run_last.
  tlvd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .box_ident_o     (box_ident_o),
    .item_ident_o    (item_ident_o),
    .elem_type_o     (elem_type_o),
    .elem_length_o   (elem_length_o),
    .value_byte_o    (value_byte_o),
    .value_last_o    (value_last_o),
    .element_count_o (element_count_o),
    .run_last_o      (run_last_o)
  );

endmodule
